@@ design/pwt_pkg.sv @@
// Shared constants, state encoding and control bundles of the partition weight tracker.
package pwt_pkg;

  localparam int NODE_COUNT  = 4096;
  localparam int PART_COUNT  = 16;
  localparam int TYPE_COUNT  = 4;
  localparam int WEIGHT_BITS = 32;

  localparam int NODE_BITS  = $clog2(NODE_COUNT);
  localparam int PART_BITS  = $clog2(PART_COUNT);
  localparam int HOME_BITS  = PART_BITS + 1;
  localparam int COUNT_BITS = NODE_BITS + 1;
  localparam int IN_W_BITS  = 16;

  // Home code of a node that belongs to no partition.
  localparam logic [HOME_BITS-1:0] UNASSIGNED = HOME_BITS'(PART_COUNT);

  // Command codes.
  localparam logic CMD_MOVE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HOME,
    ST_READ,
    ST_ADD
  } state_t;

  // Control word from the sequencer to every accumulator lane.
  typedef struct packed {
    logic                 clr;
    logic                 rd;
    logic                 sub_wr;
    logic                 add_wr;
    logic                 move;
    logic [PART_BITS-1:0] old_part;
    logic [PART_BITS-1:0] tgt_part;
  } lane_ctl_t;

  // Control word from the sequencer to the merge stage.
  typedef struct packed {
    logic                 load_clear;
    logic                 load_move;
    logic                 moved;
    logic [HOME_BITS-1:0] prior_part;
  } merge_ctl_t;

endpackage

@@ design/pwt_node_map.sv @@
// Node-to-partition table with a clearing sweep after reset and on a clear command.
module pwt_node_map (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           clear,
  input  logic [pwt_pkg::NODE_BITS-1:0]  rd_addr,
  input  logic                           wr_en,
  input  logic [pwt_pkg::NODE_BITS-1:0]  wr_addr,
  input  logic [pwt_pkg::PART_BITS-1:0]  wr_data,
  output logic [pwt_pkg::HOME_BITS-1:0]  home,
  output logic                           clearing
);
  import pwt_pkg::*;

  logic [HOME_BITS-1:0] mem [NODE_COUNT];
  logic [NODE_BITS-1:0] clr_addr;

  // Sweep control: walks every entry once, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clear) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == {NODE_BITS{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  // Single write port shared by the sweep and by moves, registered read port.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= UNASSIGNED;
    end else if (wr_en) begin
      mem[wr_addr] <= {1'b0, wr_data};
    end
    home <= mem[rd_addr];
  end

  // A move never writes while the sweep owns the port.
  assert property (@(posedge clk) disable iff (rst) wr_en |-> !clearing)
    else $error("node table written during clearing sweep");

  // The sweep only ends after the last entry.
  assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_addr) == {NODE_BITS{1'b1}})
    else $error("clearing sweep ended early");

endmodule

@@ design/pwt_lane.sv @@
// One accumulator lane: a per-partition running sum with two read ports and one write port.
module pwt_lane #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  pwt_pkg::lane_ctl_t ctl,
  input  logic [WIDTH-1:0]   delta,
  input  logic               apply,
  output logic [WIDTH-1:0]   tgt_val
);
  import pwt_pkg::*;

  logic [WIDTH-1:0]      acc [PART_COUNT];
  logic [PART_COUNT-1:0] valid;
  logic [WIDTH-1:0]      old_q;
  logic [WIDTH-1:0]      tgt_q;
  logic                  wr;
  logic [PART_BITS-1:0]  wr_addr;
  logic [WIDTH-1:0]      wr_data;

  // The target figure after the step; the old figure loses the delta.
  assign tgt_val = tgt_q + ((ctl.move && apply) ? delta : '0);
  assign wr      = (ctl.sub_wr && apply) || ctl.add_wr;
  assign wr_addr = ctl.sub_wr ? ctl.old_part : ctl.tgt_part;
  assign wr_data = ctl.sub_wr ? (old_q - delta) : tgt_val;

  // Entries that were never written since a clear read as zero.
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      valid <= '0;
    end else if (wr) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Storage and registered reads of the old and target entries.
  always_ff @(posedge clk) begin
    if (wr) begin
      acc[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      old_q <= valid[ctl.old_part] ? acc[ctl.old_part] : '0;
      tgt_q <= valid[ctl.tgt_part] ? acc[ctl.tgt_part] : '0;
    end
  end

endmodule

@@ design/pwt_merge.sv @@
// Merge stage: gathers the lane figures into one registered result word.
module pwt_merge (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  pwt_pkg::merge_ctl_t                                  ctl,
  input  logic [pwt_pkg::WEIGHT_BITS-1:0]                      total_val,
  input  logic [pwt_pkg::COUNT_BITS-1:0]                       count_val,
  input  logic [pwt_pkg::TYPE_COUNT-1:0][pwt_pkg::WEIGHT_BITS-1:0] type_val,
  output logic                                                 done,
  output logic                                                 moved,
  output logic [pwt_pkg::HOME_BITS-1:0]                        prior_part,
  output logic [pwt_pkg::WEIGHT_BITS-1:0]                      target_total,
  output logic [pwt_pkg::COUNT_BITS-1:0]                       target_count,
  output logic [pwt_pkg::TYPE_COUNT-1:0][pwt_pkg::WEIGHT_BITS-1:0] target_type
);
  import pwt_pkg::*;

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.load_clear || ctl.load_move;
    end
  end

  // Result payload: a clear reports empty figures, a move the target's figures.
  always_ff @(posedge clk) begin
    if (ctl.load_clear) begin
      moved        <= 1'b0;
      prior_part   <= UNASSIGNED;
      target_total <= '0;
      target_count <= '0;
      target_type  <= '0;
    end else if (ctl.load_move) begin
      moved        <= ctl.moved;
      prior_part   <= ctl.prior_part;
      target_total <= total_val;
      target_count <= count_val;
      target_type  <= type_val;
    end
  end

endmodule

@@ design/partition_weight_tracker_top.sv @@
// Top level of the partition weight tracker: sequencer, node table, lanes and merge stage.
//
// A move word is accepted when start is high and busy is low; busy stays high while the
// sequencer steps through ST_HOME, ST_READ and ST_ADD, and the result appears on done
// once the merge stage has registered it in ST_ADD. The steps come from the registered
// read of the node table, the registered read of the partition lanes, and the single
// write port of each lane, which takes the old partition's update and the target's update
// in turn. A clear word returns its result on the next cycle and empties the partition
// lanes at once; the node table is then swept one entry per cycle, so busy stays high
// until all 4096 entries are cleared. The same sweep runs after reset. Results are shown
// for exactly one cycle with done and cannot be held off by the receiver.
module partition_weight_tracker_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cmd,
  input  logic [pwt_pkg::NODE_BITS-1:0]    node_index,
  input  logic [pwt_pkg::PART_BITS-1:0]    target_part,
  input  logic [pwt_pkg::IN_W_BITS-1:0]    node_wt,
  input  logic signed [pwt_pkg::IN_W_BITS-1:0] type_weight_0,
  input  logic signed [pwt_pkg::IN_W_BITS-1:0] type_weight_1,
  input  logic signed [pwt_pkg::IN_W_BITS-1:0] type_weight_2,
  input  logic signed [pwt_pkg::IN_W_BITS-1:0] type_weight_3,
  output logic                             done,
  output logic                             moved,
  output logic [pwt_pkg::HOME_BITS-1:0]    prior_part,
  output logic [pwt_pkg::WEIGHT_BITS-1:0]  target_total,
  output logic [pwt_pkg::COUNT_BITS-1:0]   target_count,
  output logic [pwt_pkg::WEIGHT_BITS-1:0]  target_type_0,
  output logic [pwt_pkg::WEIGHT_BITS-1:0]  target_type_1,
  output logic [pwt_pkg::WEIGHT_BITS-1:0]  target_type_2,
  output logic [pwt_pkg::WEIGHT_BITS-1:0]  target_type_3
);
  import pwt_pkg::*;

  state_t                                 state;
  state_t                                 state_next;
  logic                                   accept;
  logic                                   clearing;
  logic [HOME_BITS-1:0]                   home;
  logic [NODE_BITS-1:0]                   node_q;
  logic [PART_BITS-1:0]                   tgt_q;
  logic [IN_W_BITS-1:0]                   weight_q;
  logic [TYPE_COUNT-1:0][IN_W_BITS-1:0]   tw_q;
  logic [HOME_BITS-1:0]                   prior_q;
  logic                                   move_q;
  lane_ctl_t                              lane_ctl;
  merge_ctl_t                             merge_ctl;
  logic                                   map_wr;
  logic [WEIGHT_BITS-1:0]                 total_val;
  logic [COUNT_BITS-1:0]                  count_val;
  logic [TYPE_COUNT-1:0][WEIGHT_BITS-1:0] type_val;
  logic [TYPE_COUNT-1:0][WEIGHT_BITS-1:0] target_type;

  assign busy   = (state != ST_IDLE) || clearing;
  assign accept = start && !busy;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_MOVE) begin
          state_next = ST_HOME;
        end
      end
      ST_HOME: state_next = ST_READ;
      ST_READ: state_next = ST_ADD;
      ST_ADD:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Word registers, held for the whole move.
  always_ff @(posedge clk) begin
    if (accept) begin
      node_q   <= node_index;
      tgt_q    <= target_part;
      weight_q <= node_wt;
      tw_q     <= {type_weight_3, type_weight_2, type_weight_1, type_weight_0};
    end
    if (state == ST_HOME) begin
      prior_q <= home;
      move_q  <= home != {1'b0, tgt_q};
    end
  end

  // Sequencer outputs.
  always_comb begin
    lane_ctl          = '0;
    merge_ctl         = '0;
    map_wr            = 1'b0;
    lane_ctl.move     = move_q;
    lane_ctl.tgt_part = tgt_q;
    lane_ctl.old_part = prior_q[PART_BITS-1:0];
    merge_ctl.moved      = move_q;
    merge_ctl.prior_part = prior_q;
    case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_CLEAR) begin
          lane_ctl.clr         = 1'b1;
          merge_ctl.load_clear = 1'b1;
        end
      end
      ST_HOME: begin
        lane_ctl.rd       = 1'b1;
        lane_ctl.old_part = home[PART_BITS-1:0];
      end
      ST_READ: begin
        lane_ctl.sub_wr = move_q && !prior_q[PART_BITS];
        map_wr          = move_q;
      end
      ST_ADD: begin
        lane_ctl.add_wr     = move_q;
        merge_ctl.load_move = 1'b1;
      end
      default: begin
      end
    endcase
  end

  pwt_node_map u_node_map (
    .clk      (clk),
    .rst      (rst),
    .clear    (accept && cmd == CMD_CLEAR),
    .rd_addr  (node_index),
    .wr_en    (map_wr),
    .wr_addr  (node_q),
    .wr_data  (tgt_q),
    .home     (home),
    .clearing (clearing)
  );

  // Total weight lane.
  pwt_lane #(.WIDTH(WEIGHT_BITS)) u_total_lane (
    .clk     (clk),
    .rst     (rst),
    .ctl     (lane_ctl),
    .delta   (WEIGHT_BITS'(weight_q)),
    .apply   (1'b1),
    .tgt_val (total_val)
  );

  // Node count lane.
  pwt_lane #(.WIDTH(COUNT_BITS)) u_count_lane (
    .clk     (clk),
    .rst     (rst),
    .ctl     (lane_ctl),
    .delta   (COUNT_BITS'(1)),
    .apply   (1'b1),
    .tgt_val (count_val)
  );

  // One lane per weight type; weights of zero or below are skipped.
  for (genvar t = 0; t < TYPE_COUNT; t++) begin : g_type
    pwt_lane #(.WIDTH(WEIGHT_BITS)) u_type_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (lane_ctl),
      .delta   (WEIGHT_BITS'(tw_q[t][IN_W_BITS-2:0])),
      .apply   (!tw_q[t][IN_W_BITS-1] && (tw_q[t] != '0)),
      .tgt_val (type_val[t])
    );
  end

  pwt_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .ctl          (merge_ctl),
    .total_val    (total_val),
    .count_val    (count_val),
    .type_val     (type_val),
    .done         (done),
    .moved        (moved),
    .prior_part   (prior_part),
    .target_total (target_total),
    .target_count (target_count),
    .target_type  (target_type)
  );

  assign target_type_0 = target_type[0];
  assign target_type_1 = target_type[1];
  assign target_type_2 = target_type[2];
  assign target_type_3 = target_type[3];

  // A result only follows the last step of a move or an accepted clear.
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_ADD) || $past(accept && cmd == CMD_CLEAR))
    else $error("result strobe without a finished word");

  // A move that reports a change never targets the partition it came from.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD) && move_q |-> prior_q != {1'b0, tgt_q})
    else $error("move flagged into its own partition");

  // No word is taken while the node table is being swept.
  assert property (@(posedge clk) disable iff (rst) clearing |-> !accept)
    else $error("word accepted during clearing sweep");

endmodule
